FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Command field encoding
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result status encoding
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Field widths fixed by the interface
    localparam int VALUE_W    = 32;
    localparam int PRIORITY_W = 16;
    localparam int COUNT_W    = 5;

    // Operation issued by the controller to the datapath
    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_ENQ_FULL,
        OP_DEQ_EMPTY
    } spq_op_t;

    typedef struct packed {
        logic    load;
        spq_op_t op;
    } spq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

`default_nettype wire

FILE: hdl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output spq_pkg::spq_cmd_t       cmd,
    input  wire spq_pkg::spq_stat_t stat
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Stall only while a result is held and the sink is not taking it
    assign in_stall  = (state_reg == S_HOLD) && out_stall;
    assign out_valid = (state_reg == S_HOLD);
    assign accept    = in_valid && !in_stall;

    // Pick the datapath operation from the command and the queue status
    always_comb
    begin
        cmd.load = accept;
        if (command == CMD_DEQUEUE)
        begin
            cmd.op = stat.empty ? OP_DEQ_EMPTY : OP_DEQ;
        end
        else
        begin
            cmd.op = stat.full ? OP_ENQ_FULL : OP_ENQ;
        end
    end

    // Next state: hold a result until the sink takes it
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (accept)
                begin
                    state_next = S_HOLD;
                end
                else if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spq_pkg::spq_cmd_t                 cmd,
    output spq_pkg::spq_stat_t                     stat,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]    in_value,
    input  wire logic signed [spq_pkg::PRIORITY_W-1:0] in_priority,
    output logic signed [spq_pkg::VALUE_W-1:0]         out_value,
    output logic signed [spq_pkg::PRIORITY_W-1:0]      out_priority,
    output logic [1:0]                                 status,
    output logic [spq_pkg::COUNT_W-1:0]                entry_count,
    output logic                                       is_empty
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // Cell array, kept sorted by ascending priority from cell 0
    logic signed [VALUE_W-1:0]    val_reg  [CAPACITY];
    logic signed [PRIORITY_W-1:0] pri_reg  [CAPACITY];
    logic signed [VALUE_W-1:0]    val_next [CAPACITY];
    logic signed [PRIORITY_W-1:0] pri_next [CAPACITY];
    logic [CAPACITY-1:0]          greater;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                count_ext;

    logic signed [VALUE_W-1:0]    out_value_next;
    logic signed [PRIORITY_W-1:0] out_priority_next;
    logic [1:0]                   status_next;

    assign stat.full  = (count_reg == CW'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    // Compare every occupied cell against the incoming priority
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            greater[i] = (CW'(i) < count_reg) && (pri_reg[i] > in_priority);
        end
    end

    // Per-cell next value: keep, take the new entry, or shift
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            case (cmd.op)
                OP_ENQ:
                begin
                    if (i > 0 && greater[(i > 0) ? i - 1 : 0])
                    begin
                        val_next[i] = val_reg[(i > 0) ? i - 1 : 0];
                        pri_next[i] = pri_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (greater[i] || (CW'(i) == count_reg))
                    begin
                        val_next[i] = in_value;
                        pri_next[i] = in_priority;
                    end
                end
                OP_DEQ:
                begin
                    if (i < CAPACITY - 1)
                    begin
                        val_next[i] = val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                        pri_next[i] = pri_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
                default:
                begin
                    val_next[i] = val_reg[i];
                    pri_next[i] = pri_reg[i];
                end
            endcase
        end
    end

    // Count update and result fields
    always_comb
    begin
        count_next        = count_reg;
        out_value_next    = '0;
        out_priority_next = '0;
        status_next       = ST_DONE;
        case (cmd.op)
            OP_ENQ:
            begin
                count_next = count_reg + CW'(1);
            end
            OP_DEQ:
            begin
                count_next        = count_reg - CW'(1);
                out_value_next    = val_reg[0];
                out_priority_next = pri_reg[0];
            end
            OP_ENQ_FULL:
            begin
                status_next = ST_FULL;
            end
            OP_DEQ_EMPTY:
            begin
                status_next = ST_EMPTY;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Report the count truncated or zero-extended to the result field width
    assign count_ext = count_next;
    generate
        if (CW >= COUNT_W)
        begin : g_cnt_trunc
            always_ff @(posedge clk)
            begin
                if (cmd.load)
                begin
                    entry_count <= count_ext[COUNT_W-1:0];
                end
            end
        end
        else
        begin : g_cnt_ext
            always_ff @(posedge clk)
            begin
                if (cmd.load)
                begin
                    entry_count <= COUNT_W'(count_ext);
                end
            end
        end
    endgenerate

    // Update the count on each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= count_next;
        end
    end

    // Update cells and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                val_reg[i] <= val_next[i];
                pri_reg[i] <= pri_next[i];
            end
            out_value    <= out_value_next;
            out_priority <= out_priority_next;
            status       <= status_next;
            is_empty     <= (count_next == '0);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Fields
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_stall  command, in_value, in_priority
// out      out_valid/out_stall  out_value, out_priority, status, entry_count,
//                               is_empty
//
// One transaction per cycle while in_stall is low: the sorted cell array
// compares every cell with the incoming priority and shifts in parallel.
// The result appears in the output register in the cycle after acceptance.
// Reset empties the queue; no clearing pass is needed.
// in_stall rises only while a result is held and out_stall is high.

module sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   command,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]     in_value,
    input  wire logic signed [spq_pkg::PRIORITY_W-1:0]  in_priority,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [spq_pkg::VALUE_W-1:0]          out_value,
    output logic signed [spq_pkg::PRIORITY_W-1:0]       out_priority,
    output logic [1:0]                                  status,
    output logic [spq_pkg::COUNT_W-1:0]                 entry_count,
    output logic                                        is_empty
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_value     (in_value),
        .in_priority  (in_priority),
        .out_value    (out_value),
        .out_priority (out_priority),
        .status       (status),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

    // A transaction always leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

    // An empty-queue dequeue reports an empty queue and zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |->
            (is_empty && out_value == '0 && out_priority == '0))
    else $error("dequeue on empty reported inconsistent result");

    // A dropped enqueue can only happen on a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> !is_empty)
    else $error("full drop reported with empty queue");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic signed [VALUE_W-1:0]    value;
        logic signed [PRIORITY_W-1:0] prio;
        logic [1:0]                   status;
        logic [COUNT_W-1:0]           count;
        logic                         empty;
    } queue_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         command;
    logic signed [VALUE_W-1:0]    in_value;
    logic signed [PRIORITY_W-1:0] in_priority;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [VALUE_W-1:0]    out_value;
    logic signed [PRIORITY_W-1:0] out_priority;
    logic [1:0]                   status;
    logic [COUNT_W-1:0]           entry_count;
    logic                         is_empty;

    // Shadow copy of the sorted store
    logic signed [VALUE_W-1:0]    shadow_value [QUEUE_DEPTH];
    logic signed [PRIORITY_W-1:0] shadow_prio [QUEUE_DEPTH];
    int                           shadow_count = 0;

    queue_result_t expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    sorted_priority_queue_core #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .in_value    (in_value),
        .in_priority (in_priority),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_value),
        .out_priority(out_priority),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one accepted transaction to the shadow store and queue its result
    task automatic predict_queue_step(input logic cmd, input logic signed [VALUE_W-1:0] v,
                                      input logic signed [PRIORITY_W-1:0] p);
        queue_result_t r;
        int            pos;
        int            i;
        r.value  = '0;
        r.prio   = '0;
        r.status = ST_DONE;
        if (cmd == CMD_ENQUEUE) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                // Insert after every entry of lower or equal priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= p)
                    pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = v;
                shadow_prio[pos]  = p;
                shadow_count++;
            end
        end
        else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                // Pop the head and shift the rest down
                r.value = shadow_value[0];
                r.prio  = shadow_prio[0];
                for (i = 1; i < shadow_count; i++) begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1]  = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        r.count = COUNT_W'(shadow_count);
        r.empty = (shadow_count == 0);
        expected_results.push_back(r);
    endtask

    // Offer one transaction, idling first at random, and hold until accepted
    task automatic send_op(input logic cmd, input logic signed [VALUE_W-1:0] v,
                           input logic signed [PRIORITY_W-1:0] p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid    <= 1'b0;
            command     <= 1'($urandom);
            in_value    <= $urandom;
            in_priority <= PRIORITY_W'($urandom);
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        in_value    <= v;
        in_priority <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_queue_step(cmd, v, p);
    endtask

    task automatic send_dequeue();
        send_op(CMD_DEQUEUE, $urandom, PRIORITY_W'($urandom));
    endtask

    // Extremes, ties, full and empty cases
    task automatic test_directed();
        send_dequeue();
        send_op(CMD_ENQUEUE, 32'sh7FFFFFFF, 16'sh7FFF);
        send_op(CMD_ENQUEUE, 32'sh80000000, 16'sh8000);
        send_op(CMD_ENQUEUE, 0, 16'sd0);
        send_op(CMD_ENQUEUE, -1, -16'sd1);
        send_op(CMD_ENQUEUE, 1, 16'sd0);
        send_op(CMD_ENQUEUE, 2, 16'sd0);
        send_op(CMD_ENQUEUE, 3, 16'sh8000);
        send_op(CMD_ENQUEUE, 4, 16'sh7FFF);
        send_op(CMD_ENQUEUE, 5, 16'sd100);
        send_op(CMD_ENQUEUE, 6, -16'sd100);
        send_op(CMD_ENQUEUE, 7, -16'sd1);
        send_op(CMD_ENQUEUE, 8, 16'sd1);
        send_op(CMD_ENQUEUE, 9, 16'sd0);
        send_op(CMD_ENQUEUE, 10, 16'sh7FFE);
        send_op(CMD_ENQUEUE, 11, 16'sh8001);
        send_op(CMD_ENQUEUE, 12, 16'sd0);
        // Queue is full here: this one is dropped
        send_op(CMD_ENQUEUE, 13, 16'sd5);
        repeat (6)
            send_dequeue();
    endtask

    // Bursts with a random enqueue bias so the queue swings between empty and full
    task automatic test_random(input int n_items);
        int                           sent;
        int                           burst;
        int                           enq_pct;
        logic                         cmd;
        logic signed [VALUE_W-1:0]    v;
        logic signed [PRIORITY_W-1:0] p;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(40, 1);
            case ($urandom_range(2))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                default: enq_pct = 80;
            endcase
            repeat (burst) begin
                cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                v = $urandom;
                case ($urandom_range(7))
                    0, 1:    p = PRIORITY_W'($urandom);
                    2:       p = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    default: p = PRIORITY_W'(int'($urandom_range(8)) - 4);
                endcase
                send_op(cmd, v, p);
                sent++;
            end
        end
    endtask

    // Stall the result side for a long stretch while enqueues keep coming
    task automatic test_backpressure();
        int i;
        hold_cycles = 80;
        for (i = 0; i < 24; i++)
            send_op(CMD_ENQUEUE, $urandom, PRIORITY_W'(int'($urandom_range(6)) - 3));
        repeat (20)
            send_dequeue();
    endtask

    // Drive the result-side stall: long hold first, else random
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        queue_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                mismatch_count++;
            end
            else begin
                e = expected_results.pop_front();
                if (out_value !== e.value) begin
                    $error("out_value: expected %0d, got %0d", e.value, out_value);
                    mismatch_count++;
                end
                if (out_priority !== e.prio) begin
                    $error("out_priority: expected %0d, got %0d", e.prio, out_priority);
                    mismatch_count++;
                end
                if (status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    mismatch_count++;
                end
                if (entry_count !== e.count) begin
                    $error("entry_count: expected %0d, got %0d", e.count, entry_count);
                    mismatch_count++;
                end
                if (is_empty !== e.empty) begin
                    $error("is_empty: expected %0d, got %0d", e.empty, is_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** sorted_priority_queue_core: FAILED **");
            $finish;
        end
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_ENQUEUE;
        in_value    = '0;
        in_priority = '0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();

        send_idle_pct = 17;
        recv_idle_pct = 80;
        test_random(500);

        send_idle_pct = 80;
        recv_idle_pct = 17;
        test_random(500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        test_backpressure();

        // Drop valid and let the remaining results drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("** sorted_priority_queue_core: PASSED **");
        else
            $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule

FILE: sorted_priority_queue_core.f
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_core.sv
sim/testbench.sv
